// ===== rtl/fdvr_pkg.sv =====
// Package: sizes, codes, transaction and control types for the domain block.
`timescale 1ns / 1ps

package fdvr_pkg;

	// Domain storage geometry.
	localparam int DOMAIN_BITS = 256;
	localparam int WORD_BITS   = 32;
	localparam int NUM_WORDS   = DOMAIN_BITS / WORD_BITS;
	localparam int IDX_W       = $clog2(DOMAIN_BITS);
	localparam int WB_W        = $clog2(WORD_BITS);
	localparam int WA_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int KC_W        = $clog2(NUM_WORDS + 1);

	localparam logic [WA_W-1:0] WA_MASK = WA_W'(NUM_WORDS - 1);
	localparam logic [WA_W-1:0] WA_LAST = WA_W'(NUM_WORDS - 1);
	localparam logic [KC_W-1:0] KC_LAST = KC_W'(NUM_WORDS);

	// Command codes.
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_TEST   = 2'd2;

	// Event codes.
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_SINGLETON = 3'd1;
	localparam logic [2:0] EV_MIN       = 3'd3;
	localparam logic [2:0] EV_MAX       = 3'd4;
	localparam logic [2:0] EV_CHANGE    = 3'd5;
	localparam logic [2:0] EV_FAIL      = 3'd6;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
		logic signed [31:0] upper_in;
	} req_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic signed [31:0] lower;
		logic signed [31:0] upper;
		logic [31:0]        count;
		logic               member;
		logic               changed;
		logic               empty_res;
		logic               single;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_BITRD,
		ST_SPAN,
		ST_FILL,
		ST_SCAN,
		ST_PUBLISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic decode;
		logic bitchk;
		logic span;
		logic fill;
		logic scan;
		logic publish;
	} dp_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_bit;
		logic need_span;
		logic need_fill;
		logic fill_last;
		logic need_scan;
		logic scan_done;
	} dp_sts_t;

endpackage

// ===== rtl/fdvr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fdvr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/fdvr_ctrl.sv =====
// Controller: sequences decode, bit check, span, fill, scan and publish steps.
`timescale 1ns / 1ps

module fdvr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fdvr_pkg::dp_ctl_t ctl,
	input  fdvr_pkg::dp_sts_t sts
);

	fdvr_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdvr_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			fdvr_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.take = 1'b1;
					state_d  = fdvr_pkg::ST_DECODE;
				end
			end
			fdvr_pkg::ST_DECODE: begin
				ctl.decode = 1'b1;
				if (sts.need_bit) begin
					state_d = fdvr_pkg::ST_BITRD;
				end else if (sts.need_span) begin
					state_d = fdvr_pkg::ST_SPAN;
				end else begin
					state_d = fdvr_pkg::ST_PUBLISH;
				end
			end
			fdvr_pkg::ST_BITRD: begin
				ctl.bitchk = 1'b1;
				state_d    = sts.need_scan ? fdvr_pkg::ST_SCAN : fdvr_pkg::ST_PUBLISH;
			end
			fdvr_pkg::ST_SPAN: begin
				ctl.span = 1'b1;
				state_d  = sts.need_fill ? fdvr_pkg::ST_FILL : fdvr_pkg::ST_PUBLISH;
			end
			fdvr_pkg::ST_FILL: begin
				ctl.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = fdvr_pkg::ST_PUBLISH;
				end
			end
			fdvr_pkg::ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = fdvr_pkg::ST_PUBLISH;
				end
			end
			fdvr_pkg::ST_PUBLISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					ctl.publish = 1'b1;
					state_d     = fdvr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdvr_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/fdvr_dp.sv =====
// Datapath: domain registers, bitmap RAM, fill mask, span and word scan logic.
`timescale 1ns / 1ps

module fdvr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  fdvr_pkg::req_t    req,
	output fdvr_pkg::rsp_t    rsp,
	input  fdvr_pkg::dp_ctl_t ctl,
	output fdvr_pkg::dp_sts_t sts
);

	localparam int IW = fdvr_pkg::IDX_W;
	localparam int AW = fdvr_pkg::WA_W;
	localparam int BW = fdvr_pkg::WB_W;
	localparam int WB = fdvr_pkg::WORD_BITS;

	// Domain state.
	logic signed [31:0] lo_q, hi_q;
	logic [31:0]        cnt_q;
	logic [2:0]         ev_q;
	logic               mode_q;     // 1: bounds form, 0: bitmap form
	logic               member_q, changed_q;

	// Per-transaction working registers.
	logic [1:0]         cmd_q;
	logic signed [31:0] v_q, up_q;
	logic               in_rng_q, eq_lo_q, eq_hi_q, scan_up_q;
	logic [2:0]         ev_pend_q;
	logic [IW-1:0]      span_q;
	logic [AW-1:0]      fw_q, cur_w_q;
	logic [fdvr_pkg::KC_W-1:0] kc_q;
	logic [WB-1:0]      word_q;
	fdvr_pkg::rsp_t     rsp_q;

	// RAM port.
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [WB-1:0] ram_wdata, ram_rdata;

	logic [IW-1:0]      vidx;
	logic [AW-1:0]      vword;
	logic [BW-1:0]      vbit;
	logic               in_rng;
	logic signed [32:0] diff;
	logic               span_neg, span_fits;
	logic [31:0]        span_cnt;
	logic [WB-1:0]      fill_word, cleared, scan_data, cand;
	logic               hit, found;
	logic [BW-1:0]      fb_lo, fb_hi, fb;
	logic [IW-1:0]      jidx, dist_up, dist_dn, off;
	logic [AW-1:0]      next_w;

	assign vidx  = v_q[IW-1:0];
	assign vword = AW'(vidx >> BW);
	assign vbit  = vidx[BW-1:0];

	assign in_rng = (cnt_q != 32'd0) && (v_q >= lo_q) && (v_q <= hi_q);

	// Span of the bounds, saturated count.
	assign diff      = {hi_q[31], hi_q} - {lo_q[31], lo_q};
	assign span_neg  = diff[32];
	assign span_fits = (diff[32:IW] == '0);
	assign span_cnt  = (diff[31:0] == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0] + 32'd1;

	// Fill mask: a bit is set when its value lies within lower..upper.
	always_comb begin
		fill_word = '0;
		off       = '0;
		for (int b = 0; b < WB; b++) begin
			off          = ((IW'(fw_q) << BW) | IW'(b)) - lo_q[IW-1:0];
			fill_word[b] = (off <= span_q);
		end
	end

	assign hit     = in_rng_q & ram_rdata[vbit];
	assign cleared = ram_rdata & ~(WB'(1) << vbit);

	// Scan: first word excludes the removed bit and everything behind it.
	assign scan_data = (kc_q == '0) ? word_q : ram_rdata;

	always_comb begin
		cand  = '0;
		fb_lo = '0;
		fb_hi = '0;
		for (int b = 0; b < WB; b++) begin
			cand[b] = scan_data[b] & ((kc_q != '0) ||
				(scan_up_q ? (BW'(b) > vbit) : (BW'(b) < vbit)));
		end
		for (int b = WB - 1; b >= 0; b--) begin
			if (cand[b]) begin
				fb_lo = BW'(b);
			end
		end
		for (int b = 0; b < WB; b++) begin
			if (cand[b]) begin
				fb_hi = BW'(b);
			end
		end
	end

	assign found   = |cand;
	assign fb      = scan_up_q ? fb_lo : fb_hi;
	assign jidx    = (IW'(cur_w_q) << BW) | IW'(fb);
	assign dist_up = jidx - vidx;
	assign dist_dn = vidx - jidx;
	assign next_w  = scan_up_q ? ((cur_w_q + AW'(1)) & fdvr_pkg::WA_MASK)
	                           : ((cur_w_q - AW'(1)) & fdvr_pkg::WA_MASK);

	// RAM access steering.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = vword;
		ram_wdata = cleared;
		ram_raddr = ctl.scan ? next_w : vword;
		if (ctl.fill) begin
			ram_we    = 1'b1;
			ram_waddr = fw_q;
			ram_wdata = fill_word;
		end else if (ctl.bitchk && cmd_q == fdvr_pkg::CMD_REMOVE && hit) begin
			ram_we = 1'b1;
		end
	end

	fdvr_ram #(
		.WIDTH(WB),
		.DEPTH(fdvr_pkg::NUM_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Status toward the controller.
	always_comb begin
		sts           = '0;
		sts.need_bit  = (cmd_q == fdvr_pkg::CMD_REMOVE || cmd_q == fdvr_pkg::CMD_TEST) &&
		                !mode_q && in_rng;
		sts.need_span = (cmd_q == fdvr_pkg::CMD_LOAD) ||
		                (cmd_q == fdvr_pkg::CMD_REMOVE && in_rng && mode_q &&
		                 (lo_q != hi_q) && ((v_q == lo_q) || (v_q == hi_q)));
		sts.need_fill = !span_neg && span_fits;
		sts.fill_last = (fw_q == fdvr_pkg::WA_LAST);
		sts.need_scan = (cmd_q == fdvr_pkg::CMD_REMOVE) && hit && (cnt_q != 32'd1) &&
		                (eq_lo_q || eq_hi_q);
		sts.scan_done = found || (kc_q == fdvr_pkg::KC_LAST);
	end

	// Domain state and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q      <= '0;
			hi_q      <= '0;
			cnt_q     <= 32'd1;
			ev_q      <= fdvr_pkg::EV_NONE;
			mode_q    <= 1'b1;
			member_q  <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				member_q  <= 1'b0;
				changed_q <= 1'b0;
			end
			if (ctl.decode) begin
				unique case (cmd_q)
					fdvr_pkg::CMD_LOAD: begin
						lo_q   <= v_q;
						hi_q   <= up_q;
						mode_q <= 1'b1;
					end
					fdvr_pkg::CMD_REMOVE: begin
						if (in_rng && mode_q) begin
							if (lo_q == hi_q) begin
								cnt_q     <= '0;
								ev_q      <= fdvr_pkg::EV_FAIL;
								changed_q <= 1'b1;
							end else if (v_q == lo_q) begin
								lo_q      <= lo_q + 32'sd1;
								changed_q <= 1'b1;
							end else if (v_q == hi_q) begin
								hi_q      <= hi_q - 32'sd1;
								changed_q <= 1'b1;
							end
						end
					end
					fdvr_pkg::CMD_TEST: begin
						if (mode_q) begin
							member_q <= in_rng;
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.span) begin
				if (span_neg) begin
					cnt_q <= '0;
					ev_q  <= fdvr_pkg::EV_FAIL;
				end else begin
					cnt_q <= span_cnt;
					if (diff == '0) begin
						ev_q <= fdvr_pkg::EV_SINGLETON;
					end else if (cmd_q == fdvr_pkg::CMD_LOAD) begin
						ev_q <= fdvr_pkg::EV_NONE;
					end else begin
						ev_q <= ev_pend_q;
					end
				end
			end
			if (ctl.fill && sts.fill_last) begin
				mode_q <= 1'b0;
			end
			if (ctl.bitchk) begin
				if (cmd_q == fdvr_pkg::CMD_TEST) begin
					member_q <= hit;
				end else if (hit) begin
					cnt_q <= cnt_q - 32'd1;
					if (cnt_q == 32'd1) begin
						ev_q      <= fdvr_pkg::EV_FAIL;
						changed_q <= 1'b1;
					end else if (!eq_lo_q && !eq_hi_q) begin
						ev_q <= fdvr_pkg::EV_CHANGE;
					end
				end
			end
			if (ctl.scan && found) begin
				if (scan_up_q) begin
					lo_q <= v_q + $signed(32'(dist_up));
				end else begin
					hi_q <= v_q - $signed(32'(dist_dn));
				end
				if (cnt_q == 32'd1) begin
					ev_q <= fdvr_pkg::EV_SINGLETON;
				end else begin
					ev_q <= scan_up_q ? fdvr_pkg::EV_MIN : fdvr_pkg::EV_MAX;
				end
				changed_q <= 1'b1;
			end
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= req.cmd;
			v_q   <= req.value;
			up_q  <= req.upper_in;
		end
		if (ctl.decode) begin
			in_rng_q  <= in_rng;
			eq_lo_q   <= (v_q == lo_q);
			eq_hi_q   <= (v_q == hi_q);
			ev_pend_q <= (v_q == lo_q) ? fdvr_pkg::EV_MIN : fdvr_pkg::EV_MAX;
		end
		if (ctl.span) begin
			span_q <= diff[IW-1:0];
			fw_q   <= '0;
		end
		if (ctl.fill) begin
			fw_q <= fw_q + AW'(1);
		end
		if (ctl.bitchk) begin
			word_q    <= cleared;
			cur_w_q   <= vword;
			kc_q      <= '0;
			scan_up_q <= eq_lo_q;
		end
		if (ctl.scan) begin
			cur_w_q <= next_w;
			kc_q    <= kc_q + fdvr_pkg::KC_W'(1);
		end
		if (ctl.publish) begin
			rsp_q.event_res <= ev_q;
			rsp_q.lower     <= lo_q;
			rsp_q.upper     <= hi_q;
			rsp_q.count     <= cnt_q;
			rsp_q.member    <= member_q;
			rsp_q.changed   <= changed_q;
			rsp_q.empty_res <= (ev_q == fdvr_pkg::EV_FAIL);
			rsp_q.single    <= (lo_q == hi_q) && (cnt_q != 32'd0);
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/finite_domain_value_removal.sv =====
// Top level: one finite integer domain with load, remove and membership test.
`timescale 1ns / 1ps

// Usage
// - Request channel (req, req_valid, req_stall): one transaction carries a
//   command (load bounds, remove value, test membership), a value and an upper
//   bound. A transaction is taken when req_valid is high and req_stall is low.
// - Response channel (rsp, rsp_valid, rsp_stall): every request yields exactly
//   one response with the event code, bounds, count and the member, changed,
//   empty and single flags, in request order.
// - One request at a time. After decode, a request goes straight to publish
//   for a bounds-form test, an unknown command, or a value outside the
//   domain, interior in bounds form or last in bounds form; through a bit
//   check for another bitmap test or a bitmap remove that moves no bound;
//   through the span step for a load or bounds-form bound removal, then a
//   fill when the bitmap is written, one word per cycle; through a bit check
//   and a word scan for a bitmap bound removal, one word scanned per cycle.
//   The next request is taken once the response is published.
// - A finished response waits in the output register while rsp_stall is high;
//   the next request is still accepted and worked on, and only its publish
//   step waits for the register to free up.
// - Reset (arst_n low) gives the domain {0} in bounds form, event none, no
//   response pending. The bitmap RAM needs no clearing: it is read only in
//   bitmap form, and every entry is written before that form is entered.
module finite_domain_value_removal (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fdvr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fdvr_pkg::rsp_t rsp
);

	fdvr_pkg::dp_ctl_t ctl;
	fdvr_pkg::dp_sts_t sts;

	// Sequence the work for each transaction.
	fdvr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

	// Hold the domain and compute the results.
	fdvr_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.ctl   (ctl),
		.sts   (sts)
	);

	// A failed domain always reports zero values.
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.empty_res |-> rsp.count == 32'd0)
		else $error("fail event with nonzero count");

	// A single-valued domain holds exactly one value.
	a_single_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.single |-> rsp.count == 32'd1)
		else $error("singleton with count other than one");

	// A membership result and a change flag never come from the same transaction.
	a_member_changed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.member && rsp.changed))
		else $error("member and changed both set");

	// A nonempty domain never reports lower above upper.
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.count != 32'd0 |-> rsp.lower <= rsp.upper)
		else $error("nonempty domain with lower above upper");

endmodule
